### rtl/ssid_pkg.sv
// Shared types and constants for the sorted set insert/delete unit.
package ssid_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = 6;
  localparam int VAL_W    = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HEADER,
    ST_LIST_RD,
    ST_LIST_WR
  } state_t;

  typedef struct packed {
    logic               is_header;
    logic [CNT_W-1:0]   count;
    logic [VAL_W-1:0]   element;
    logic               dropped;
    logic               last;
  } res_t;

  typedef struct packed {
    logic               re;
    logic [ADDR_W-1:0]  raddr;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VAL_W-1:0]   wdata;
  } ram_req_t;

endpackage

### rtl/ssid_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module ssid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ssid_ctrl.sv
// Sequencer: search pass over the store, header, then rewrite-and-list pass.
module ssid_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic                        in_op,
  input  logic [ssid_pkg::VAL_W-1:0]  in_value,
  input  logic                        slot_free,
  output logic                        push,
  output ssid_pkg::res_t              res,
  output ssid_pkg::ram_req_t          ram_req,
  input  logic [ssid_pkg::VAL_W-1:0]  ram_rdata
);
  import ssid_pkg::*;

  state_t            state, state_next;
  logic              op_r;
  logic [VAL_W-1:0]  val_r;
  logic [CNT_W-1:0]  count;      // stored values, committed at header
  logic [CNT_W-1:0]  ocnt;       // count before this operation
  logic [CNT_W-1:0]  ncnt;       // count after this operation
  logic [CNT_W-1:0]  ridx;       // next search address
  logic [CNT_W-1:0]  rd_idx;     // address of the data now on ram_rdata
  logic              rv;         // search read in flight
  logic [CNT_W-1:0]  pos;
  logic              ins, del, drop;
  logic [CNT_W-1:0]  j;
  logic [VAL_W-1:0]  prev;

  logic              hit, srch_done, present;
  logic [CNT_W-1:0]  pos_found;
  logic              ins_c, del_c, drop_c;
  logic [VAL_W-1:0]  elem;
  logic              elem_last;

  assign hit       = rv && ($signed(ram_rdata) >= $signed(val_r));
  assign srch_done = hit || ((ridx == ocnt) && !rv);
  assign pos_found = hit ? rd_idx : ocnt;
  assign present   = hit && (ram_rdata == val_r);
  assign ins_c     = (op_r == OP_INSERT) && !present && (ocnt < CNT_W'(CAPACITY));
  assign drop_c    = (op_r == OP_INSERT) && !present && (ocnt >= CNT_W'(CAPACITY));
  assign del_c     = (op_r == OP_DELETE) && present;

  // New entry j from the old contents: insert shifts up by one past pos,
  // delete reads one ahead (handled by the read address).
  always_comb begin
    elem = ram_rdata;
    if (ins) begin
      if (j == pos) begin
        elem = val_r;
      end else if (j > pos) begin
        elem = prev;
      end
    end
  end
  assign elem_last = (j == ncnt - CNT_W'(1));

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    push       = 1'b0;
    res        = '0;
    ram_req    = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!hit && (ridx < ocnt)) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ridx[ADDR_W-1:0];
        end
        if (srch_done) begin
          state_next = ST_HEADER;
        end
      end
      ST_HEADER: begin
        if (slot_free) begin
          push          = 1'b1;
          res.is_header = 1'b1;
          res.count     = ncnt;
          res.dropped   = drop;
          res.last      = (ncnt == '0);
          state_next    = (ncnt == '0) ? ST_IDLE : ST_LIST_RD;
        end
      end
      ST_LIST_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = (del && (j >= pos)) ? ADDR_W'(j + CNT_W'(1)) : j[ADDR_W-1:0];
        state_next    = ST_LIST_WR;
      end
      ST_LIST_WR: begin
        if (slot_free) begin
          push          = 1'b1;
          res.element   = elem;
          res.last      = elem_last;
          ram_req.we    = ins || del;
          ram_req.waddr = j[ADDR_W-1:0];
          ram_req.wdata = elem;
          state_next    = elem_last ? ST_IDLE : ST_LIST_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      rv    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && s_tvalid) begin
        op_r  <= in_op;
        val_r <= in_value;
        ocnt  <= count;
        ridx  <= '0;
        rv    <= 1'b0;
      end
      if (state == ST_SEARCH) begin
        rv <= ram_req.re;
        if (ram_req.re) begin
          rd_idx <= ridx;
          ridx   <= ridx + CNT_W'(1);
        end
        if (srch_done) begin
          pos  <= pos_found;
          ins  <= ins_c;
          del  <= del_c;
          drop <= drop_c;
          ncnt <= ins_c ? ocnt + CNT_W'(1) : (del_c ? ocnt - CNT_W'(1) : ocnt);
        end
      end
      if (state == ST_HEADER && slot_free) begin
        count <= ncnt;
        j     <= '0;
      end
      if (state == ST_LIST_WR && slot_free) begin
        prev <= ram_rdata;
        j    <= j + CNT_W'(1);
      end
    end
  end

endmodule

### rtl/sorted_set_insert_delete_unit.sv
// Sorted set insert/delete unit: top level with the result output register.
//
// Keeps up to CAPACITY distinct signed 32-bit values in ascending order in
// one RAM. Each slave beat is one operation: s_tuser = op (insert/delete),
// s_tdata = value. Duplicate inserts and absent deletes change nothing;
// an insert into a full set is dropped and flagged on the header.
// After each operation the master side lists the set: one header beat
// (m_tuser = 1) with the new count and the dropped flag, then one beat per
// stored value in ascending order; m_tlast marks the final beat (the header
// itself when the set is empty).
// Each operation runs the accept cycle, a search pass that reads the RAM
// one entry per cycle, the header, then per listed value a RAM read and
// then the rewrite of the same slot and the output beat. The store has a
// single read port. One operation is in work at a time; s_tready is
// high only between operations.
// A stall on m_tready holds the current beat in the output register and
// pauses the sequencer. Reset (rst, synchronous) empties the set; the RAM
// needs no clearing since data read from entries at or above the count is never used.
module sorted_set_insert_delete_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [5:0] count, [37:6] element, [38] dropped, [39] zero
  output logic        m_tuser,   // [0] is_header
  output logic        m_tlast
);
  import ssid_pkg::*;

  logic             slot_free;
  logic             push;
  res_t             res;
  ram_req_t         ram_req;
  logic [VAL_W-1:0] ram_rdata;
  res_t             obuf;

  // output beat register: free when empty or being taken this cycle
  assign slot_free = !m_tvalid || m_tready;

  ssid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .in_op     (s_tuser),
    .in_value  (s_tdata),
    .slot_free (slot_free),
    .push      (push),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  ssid_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (slot_free) begin
      m_tvalid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && push) begin
      obuf <= res;
    end
  end

  assign m_tdata = {1'b0, obuf.dropped, obuf.element, obuf.count};
  assign m_tuser = obuf.is_header;
  assign m_tlast = obuf.last;

endmodule

### rtl/ssid_checker.sv
// Port-level checker for the sorted set unit, bound to the top level.
module ssid_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);
  import ssid_pkg::*;

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled beat changed");

  // header count within capacity, and tlast on header iff set is empty
  a_hdr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[5:0] <= CNT_W'(CAPACITY)) &&
                            (m_tlast == (m_tdata[5:0] == 6'd0)))
    else $error("bad header beat");

  // element beats carry no count or dropped flag
  a_elem: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[5:0] == 6'd0) && !m_tdata[38])
    else $error("bad element beat");

  // no new operation is taken while a listing is still being driven out
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready during listing");

endmodule

bind sorted_set_insert_delete_unit ssid_checker u_ssid_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

### test/tb_sorted_set_insert_delete_unit.sv
// Testbench for the sorted set insert/delete unit: random ops, mirrored set, beat-by-beat checks.
module tb_sorted_set_insert_delete_unit;
  import ssid_pkg::*;

  // Mirror of the stored set. Each accepted op is applied here, and the full
  // listing that it produces (header, then the values in ascending order) is
  // queued. Every master beat is then matched against the oldest queued beat.
  class sorted_set_mirror;
    logic signed [VAL_W-1:0] vals [CAPACITY];
    int                      cnt;
    res_t                    listing_q [$];
    int                      mismatches;
    int                      ops_seen;
    int                      beats_seen;
    int                      refused;
    int                      dup_inserts;
    int                      absent_deletes;
    int                      peak;

    function void apply_op(logic op, logic signed [VAL_W-1:0] v);
      int   pos;
      int   k;
      bit   present;
      bit   drop;
      res_t r;
      pos  = 0;
      drop = 1'b0;
      while (pos < cnt && vals[pos] < v) pos++;
      present = (pos < cnt) && (vals[pos] == v);
      ops_seen++;
      if (op == OP_INSERT) begin
        if (present) begin
          dup_inserts++;
        end else if (cnt >= CAPACITY) begin
          drop = 1'b1;
          refused++;
        end else begin
          for (k = cnt; k > pos; k--) vals[k] = vals[k-1];
          vals[pos] = v;
          cnt++;
        end
      end else begin
        if (present) begin
          for (k = pos; k + 1 < cnt; k++) vals[k] = vals[k+1];
          cnt--;
        end else begin
          absent_deletes++;
        end
      end
      if (cnt > peak) peak = cnt;
      r.is_header = 1'b1;
      r.count     = CNT_W'(cnt);
      r.element   = '0;
      r.dropped   = drop;
      r.last      = (cnt == 0);
      listing_q.push_back(r);
      for (k = 0; k < cnt; k++) begin
        r.is_header = 1'b0;
        r.count     = '0;
        r.element   = vals[k];
        r.dropped   = 1'b0;
        r.last      = (k + 1 == cnt);
        listing_q.push_back(r);
      end
    endfunction

    function void check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_beat(res_t got);
      res_t want;
      beats_seen++;
      if (listing_q.size() == 0) begin
        $error("unexpected listing beat: is_header %0b count %0d element %0h",
               got.is_header, got.count, got.element);
        mismatches++;
        return;
      end
      want = listing_q.pop_front();
      check_field("is_header", VAL_W'(want.is_header), VAL_W'(got.is_header));
      check_field("count",     VAL_W'(want.count),     VAL_W'(got.count));
      check_field("element",   want.element,           got.element);
      check_field("dropped",   VAL_W'(want.dropped),   VAL_W'(got.dropped));
      check_field("last",      VAL_W'(want.last),      VAL_W'(got.last));
    endfunction

    function int pending();
      return listing_q.size();
    endfunction

    function logic [VAL_W-1:0] any_stored();
      return vals[$urandom_range(cnt - 1)];
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] value
  logic        s_tuser  = 1'b0; // [0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [5:0] count, [37:6] element, [38] dropped, [39] zero
  logic        m_tuser;         // [0] is_header
  logic        m_tlast;

  sorted_set_mirror mirror = new();
  bit               no_idle = 1'b0;  // both sides stream flat out while set
  int               ops_sent = 0;

  sorted_set_insert_delete_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // Hard stop well past the slowest legal run (~340 ops, each up to 33 beats
  // under 38% receiver stalls plus a search/list pass).
  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

  // Receiver: take beats when valid and ready line up at the edge, then pick
  // the next ready value. Outputs read here are pre-edge values.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      mirror.match_beat('{is_header: m_tuser, count: m_tdata[5:0],
                          element: m_tdata[37:6], dropped: m_tdata[38], last: m_tlast});
    end
    m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 38);
  end

  // One op beat. Valid stays high from one beat to the next unless a gap is
  // chosen, so it is never dropped and raised within a single edge.
  task automatic send_op(input logic op, input logic [31:0] val);
    while (!no_idle && $urandom_range(99) < 38) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    mirror.apply_op(op, val);
    ops_sent++;
    // Long stretch with no idling on either side.
    no_idle = (ops_sent >= 120 && ops_sent < 180);
  endtask

  // Operand for a random op. Deletes mostly target stored values so the set
  // actually drains; inserts mix wide random values, a small clustered pool
  // (lots of neighbors and repeats), stored values and the range ends.
  function automatic logic [31:0] pick_value(input logic op);
    int r;
    r = $urandom_range(99);
    if (mirror.cnt > 0 && ((op == OP_DELETE && r < 75) || (op == OP_INSERT && r < 20)))
      return mirror.any_stored();
    if (r < 50) return $urandom();
    if (r < 90) return 32'($signed($urandom_range(47)) - 24);
    return $urandom_range(1) ? (32'h7fffffff - $urandom_range(3))
                             : (32'h80000000 + $urandom_range(3));
  endfunction

  initial begin
    int  ep;
    int  len;
    int  kind;
    int  ins_pct;
    int  i;
    logic op;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: duplicate insert, absent deletes, delete of the only value,
    // delete on an empty set, range ends, alternating bit patterns, and
    // deletes at the head, tail and middle of the order.
    send_op(OP_INSERT, 32'h0);
    send_op(OP_INSERT, 32'h0);
    send_op(OP_DELETE, 32'h5);
    send_op(OP_DELETE, 32'h0);
    send_op(OP_DELETE, 32'h0);
    send_op(OP_INSERT, 32'h7fffffff);
    send_op(OP_INSERT, 32'h80000000);
    send_op(OP_INSERT, 32'hffffffff);
    send_op(OP_INSERT, 32'h00000001);
    send_op(OP_INSERT, 32'h55555555);
    send_op(OP_INSERT, 32'haaaaaaaa);
    send_op(OP_DELETE, 32'h80000000);
    send_op(OP_DELETE, 32'h7fffffff);
    send_op(OP_DELETE, 32'h00000001);
    send_op(OP_DELETE, 32'hffffffff);
    send_op(OP_DELETE, 32'h55555555);
    send_op(OP_DELETE, 32'haaaaaaaa);

    // Random episodes. The first one fills the set past capacity (refused
    // inserts, duplicates into a full set); later ones fill, drain or mix.
    ep = 0;
    while (ops_sent < 300) begin
      kind = (ep == 0) ? 0 : $urandom_range(2);
      len  = (ep == 0) ? 40 : $urandom_range(10, 40);
      case (kind)
        0: ins_pct = (ep == 0) ? 100 : 90;
        1: ins_pct = 15;
        default: ins_pct = 50;
      endcase
      for (i = 0; i < len; i++) begin
        op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_DELETE;
        send_op(op, pick_value(op));
      end
      // Hold off until the whole listing backlog is out, sometimes.
      if (ep == 0 || $urandom_range(2) == 0) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (mirror.pending() != 0) @(posedge clk);
      end
      ep++;
    end
    s_tvalid <= 1'b0;

    while (mirror.pending() != 0) @(posedge clk);
    // Anything the unit sends after the last expected beat shows up as an
    // unexpected beat.
    repeat (3 * CAPACITY + 40) @(posedge clk);

    $display("covered %0d ops and %0d listing beats; peak count %0d, %0d refused inserts",
             mirror.ops_seen, mirror.beats_seen, mirror.peak, mirror.refused);
    $display("duplicate inserts %0d, absent deletes %0d, mismatches %0d",
             mirror.dup_inserts, mirror.absent_deletes, mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
